// ===== rtl/range_scan_corner_detector_unit_defines.svh =====
// assertion macros for the range scan corner detector
// needs a clk and an active-low arst_n in the scope of each use
`ifndef RANGE_SCAN_CORNER_DETECTOR_UNIT_DEFINES_SVH
`define RANGE_SCAN_CORNER_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RSCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rscd assertion failed");
`define RSCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rscd assertion failed");
`else
`define RSCD_ASSERT_NOW(label, ante, cons)
`define RSCD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/rscd_pkg.sv =====
// shared constants for the range scan corner detector
// no dependencies
`timescale 1ns / 1ps

package rscd_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int HALF_WINDOW = 3;
	localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;
	localparam int HIST_LEN    = WIN_LEN - 1;

	localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
	localparam int IDX_W  = 12;
	localparam int THR_W  = 16;
	localparam int SEP_W  = 4;
	localparam int FRAC_W = 16;
	localparam int PROD_W = THR_W + SAMPLE_BITS;
	localparam int CMP_W  = SAMPLE_BITS + FRAC_W + 2;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_REL_THRESHOLD  = CFG_ADDR_W'(0);
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_SEPARATION = CFG_ADDR_W'(1);

	localparam logic [THR_W-1:0] REL_THRESHOLD_RST  = THR_W'(655);
	localparam logic [SEP_W-1:0] MIN_SEPARATION_RST = SEP_W'(3);

	localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_SAMPLES);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(2 * HALF_WINDOW);
	localparam logic [CNT_W-1:0] CNT_HALF  = CNT_W'(HALF_WINDOW);

endpackage

// ===== rtl/range_scan_corner_detector_unit.sv =====
// range scan corner detector, top level
// depends on rscd_pkg, rscd_corner_test and range_scan_corner_detector_unit_defines.svh
`timescale 1ns / 1ps
`include "range_scan_corner_detector_unit_defines.svh"

// Range samples of a scan enter on the s_ group, one per request, in beam
// order; s_tlast marks the last sample of a scan. Results leave on the m_
// group: m_tuser carries the corner flag, m_tdata the corner index, m_tlast
// marks the result that closes a scan. A sample gives a result when its window
// centre is a corner not suppressed by min_separation, or when it carries
// s_tlast; other samples give none. A result reaches m_tvalid in the cycle
// after its sample is accepted. Throughput is one sample per cycle: the
// window, counter and corner test sit between the input handshake and one
// output register; the corner test is a single 16x16 multiply and compares.
// When the receiver stalls, the output register holds its result and s_tready
// falls only while that register is full and m_tready is low.
// Configuration writes on cfg_we set rel_threshold (index 0) and min_separation
// (index 1); the user must issue them while the block is idle, as the block does not enforce it.
// Reset clears the scan state and loads rel_threshold = 655 and
// min_separation = 3; no output is valid after reset.

module range_scan_corner_detector_unit
	import rscd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] range_sample
	input  logic                  s_tlast,   // scan_last

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // [11:0] corner_index
	output logic                  m_tuser,   // corner_found
	output logic                  m_tlast    // scan_end
);

	logic [THR_W-1:0]       rel_threshold_q;
	logic [SEP_W-1:0]       min_separation_q;

	logic [SAMPLE_BITS-1:0] window_q [HIST_LEN];
	logic [CNT_W-1:0]       count_q;
	logic [IDX_W-1:0]       prev_corner_q;
	logic                   corner_seen_q;

	logic                   out_valid_q;
	logic                   found_q;
	logic [IDX_W-1:0]       index_q;
	logic                   scan_end_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   storing;
	logic                   testing;
	logic                   is_corner;
	logic [IDX_W-1:0]       centre_idx;
	logic [IDX_W-1:0]       idx_gap;
	logic                   suppressed;
	logic                   found;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rel_threshold_q  <= REL_THRESHOLD_RST;
			min_separation_q <= MIN_SEPARATION_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_REL_THRESHOLD: begin
					rel_threshold_q <= cfg_wdata[THR_W-1:0];
				end
				REG_MIN_SEPARATION: begin
					min_separation_q <= cfg_wdata[SEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign sample   = s_tdata[SAMPLE_BITS-1:0];

	assign storing  = count_q < CNT_MAX;
	assign testing  = storing && (count_q >= CNT_FULL);

	// window_q[0] is the newest stored sample, so the centre after the shift
	// is window_q[HALF_WINDOW-1] and the oldest is the last entry
	rscd_corner_test u_test (
		.newest        (sample),
		.centre        (window_q[HALF_WINDOW-1]),
		.oldest        (window_q[HIST_LEN-1]),
		.rel_threshold (rel_threshold_q),
		.is_corner     (is_corner)
	);

	assign centre_idx = IDX_W'(count_q - CNT_HALF);
	assign idx_gap    = centre_idx - prev_corner_q;
	assign suppressed = corner_seen_q && (centre_idx > prev_corner_q) &&
		(idx_gap <= IDX_W'(min_separation_q));
	assign found      = testing && is_corner && !suppressed;

	// sample history, only read once the scan has filled it
	always_ff @(posedge clk) begin
		if (accept && storing) begin
			window_q[0] <= sample;
			for (int k = 1; k < HIST_LEN; k++) begin
				window_q[k] <= window_q[k-1];
			end
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			prev_corner_q <= '0;
			corner_seen_q <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				count_q       <= '0;
				prev_corner_q <= '0;
				corner_seen_q <= 1'b0;
			end else begin
				if (storing) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (found) begin
					prev_corner_q <= centre_idx;
					corner_seen_q <= 1'b1;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= found || s_tlast;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q    <= found;
			index_q    <= found ? centre_idx : '0;
			scan_end_q <= s_tlast;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - IDX_W){1'b0}}, index_q};
	assign m_tuser  = found_q;
	assign m_tlast  = scan_end_q;

	`RSCD_ASSERT_NOW(a_result_has_cause, out_valid_q, found_q || scan_end_q)
	`RSCD_ASSERT_NOW(a_index_zero_without_corner, out_valid_q && !found_q, index_q == '0)
	`RSCD_ASSERT_NEXT(a_scan_cleared, accept && s_tlast, count_q == '0 && !corner_seen_q)
	`RSCD_ASSERT_NOW(a_count_bounded, 1'b1, count_q <= CNT_MAX)

endmodule

// ===== rtl/rscd_corner_test.sv =====
// peak / valley test on the centre of the sample window
// depends on rscd_pkg
`timescale 1ns / 1ps

module rscd_corner_test
	import rscd_pkg::*;
(
	input  logic [SAMPLE_BITS-1:0] newest,
	input  logic [SAMPLE_BITS-1:0] centre,
	input  logic [SAMPLE_BITS-1:0] oldest,
	input  logic [THR_W-1:0]       rel_threshold,
	output logic                   is_corner
);

	logic signed [SAMPLE_BITS:0] back_d;
	logic signed [SAMPLE_BITS:0] fwd_d;
	logic signed [CMP_W-1:0]     back_x;
	logic signed [CMP_W-1:0]     fwd_x;
	logic        [PROD_W-1:0]    prod;
	logic signed [CMP_W-1:0]     thr_x;
	logic signed [CMP_W-1:0]     thr_neg;
	logic                        peak;
	logic                        valley;

	assign back_d = $signed({1'b0, centre}) - $signed({1'b0, oldest});
	assign fwd_d  = $signed({1'b0, newest}) - $signed({1'b0, centre});

	// both differences scaled by 2^16 to meet the q0.16 threshold exactly
	assign back_x = {{(CMP_W - SAMPLE_BITS - 1 - FRAC_W){back_d[SAMPLE_BITS]}},
		back_d, {FRAC_W{1'b0}}};
	assign fwd_x  = {{(CMP_W - SAMPLE_BITS - 1 - FRAC_W){fwd_d[SAMPLE_BITS]}},
		fwd_d, {FRAC_W{1'b0}}};

	assign prod    = PROD_W'(rel_threshold) * PROD_W'(centre);
	assign thr_x   = $signed({{(CMP_W - PROD_W){1'b0}}, prod});
	assign thr_neg = -thr_x;

	assign peak      = (back_x > thr_x) && (fwd_x < thr_neg);
	assign valley    = (fwd_x > thr_x) && (back_x < thr_neg);
	assign is_corner = peak || valley;

endmodule
